// ===== hw/rtl/fuzzy_controller_five_set_top_defines.svh =====
// Assertion macros used by the fuzzy controller top level.
`ifndef FUZZY_CONTROLLER_FIVE_SET_TOP_DEFINES_SVH
`define FUZZY_CONTROLLER_FIVE_SET_TOP_DEFINES_SVH

// Same-cycle implication.
`define FCFS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FCFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/fcfs_pkg.sv =====
// Types and constants of the five-set fuzzy controller.
`default_nettype none
package fcfs_pkg;
   localparam int NUM_SETS   = 5;
   localparam int PT_W       = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int GRADE_W    = 7;
   localparam int GNUM_W     = 23;
   localparam int GDEN_W     = 17;
   localparam int MAG_W      = 24;
   localparam int DEN_W      = 9;
   localparam int DRV_W      = 16;
   localparam int PROD_W     = 23;
   localparam int SUM_W      = 25;

   localparam logic [GRADE_W-1:0] GRADE_FULL = 7'd100;

   localparam logic [CSR_IDX_W-1:0] CSR_TRAP_NEG_LARGE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAP_NEG         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAP_ZERO        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAP_POS         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAP_POS_LARGE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTERS_LOW      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_POS_LARGE = 3'd6;

   typedef enum logic [1:0] {
      MODE_ZERO = 2'd0,
      MODE_FULL = 2'd1,
      MODE_RISE = 2'd2,
      MODE_FALL = 2'd3
   } mode_type;

   typedef mode_type [NUM_SETS-1:0] mode_vec_type;
   typedef logic [NUM_SETS-1:0][CSR_DATA_W-1:0] trap_bank_type;
   typedef logic signed [NUM_SETS-1:0][PT_W-1:0] peak_bank_type;

   typedef struct packed {
      logic signed [PT_W-1:0] set_point;
      logic signed [PT_W-1:0] measurement;
   } req_type;

   typedef struct packed {
      logic signed [DRV_W-1:0] drive;
      logic                    no_membership;
   } rsp_type;

   typedef struct packed {
      logic                                  valid;
      mode_vec_type                          mode;
      logic [NUM_SETS-1:0][GNUM_W-1:0]       num;
      logic [NUM_SETS-1:0][GDEN_W-1:0]       den;
   } front_type;

   typedef struct packed {
      logic sign;
      logic empty;
   } quo_side_type;

   typedef struct packed {
      logic               valid;
      quo_side_type       side;
      logic [MAG_W-1:0]   mag;
      logic [DEN_W-1:0]   den;
   } defuzz_type;
endpackage
`default_nettype wire

// ===== hw/rtl/fcfs_pipe_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, several lanes.
`default_nettype none
module fcfs_pipe_div #(
   parameter int LANES = 1,
   parameter int NW    = 8,
   parameter int DW    = 4,
   parameter int QW    = 4,
   parameter int SW    = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [LANES-1:0][NW-1:0]    in_num,
   input  logic [LANES-1:0][DW-1:0]    in_den,
   input  logic [SW-1:0]               in_side,
   output logic                        out_valid,
   output logic [LANES-1:0][QW-1:0]    out_quo,
   output logic [SW-1:0]               out_side
);
   localparam int CW = DW + QW;
   localparam int MW = (NW > CW) ? NW : CW;

   logic                     val_ff  [QW];
   logic [LANES-1:0][NW-1:0] rem_ff  [QW];
   logic [LANES-1:0][DW-1:0] den_ff  [QW];
   logic [LANES-1:0][QW-1:0] quo_ff  [QW];
   logic [SW-1:0]            side_ff [QW];

   genvar k, l;
   for (k = 0; k < QW; k++) begin : g_stage
      logic                     vin;
      logic [LANES-1:0][NW-1:0] rin;
      logic [LANES-1:0][DW-1:0] din;
      logic [LANES-1:0][QW-1:0] qin;
      logic [SW-1:0]            sin;
      logic [LANES-1:0][NW-1:0] rem_in;
      logic [LANES-1:0][QW-1:0] quo_in;

      if (k == 0) begin : g_first
         assign vin = in_valid;
         assign rin = in_num;
         assign din = in_den;
         assign qin = '0;
         assign sin = in_side;
      end else begin : g_next
         assign vin = val_ff[k-1];
         assign rin = rem_ff[k-1];
         assign din = den_ff[k-1];
         assign qin = quo_ff[k-1];
         assign sin = side_ff[k-1];
      end

      for (l = 0; l < LANES; l++) begin : g_lane
         logic [MW-1:0] r_ext;
         logic [MW-1:0] d_sh;
         logic          take;
         assign r_ext = MW'(rin[l]);
         assign d_sh  = MW'(din[l]) << (QW - 1 - k);
         assign take  = (r_ext >= d_sh);
         assign rem_in[l] = take ? NW'(r_ext - d_sh) : rin[l];
         assign quo_in[l] = take ? (qin[l] | (QW'(1) << (QW - 1 - k))) : qin[l];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[k] <= 1'b0;
         end else if (en) begin
            val_ff[k] <= vin;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= din;
            quo_ff[k]  <= quo_in;
            side_ff[k] <= sin;
         end
      end
   end

   assign out_valid = val_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_side  = side_ff[QW-1];
endmodule
`default_nettype wire

// ===== hw/rtl/fcfs_front.sv =====
// Error forming, saturation and trapezoid region decode with divider operands.
`default_nettype none
module fcfs_front #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  fcfs_pkg::req_type      in_req,
   input  fcfs_pkg::trap_bank_type traps,
   output fcfs_pkg::front_type    out
);
   import fcfs_pkg::*;

   localparam int EW = (DATA_WIDTH < 17) ? DATA_WIDTH : 17;
   localparam logic signed [EW-1:0] E_MAX = {1'b0, {(EW-1){1'b1}}};
   localparam logic signed [EW-1:0] E_MIN = {1'b1, {(EW-1){1'b0}}};

   logic signed [17:0]   diff;
   logic signed [17:0]   max18, min18;
   logic signed [EW-1:0] e_in, e_ff;
   logic                 e_val_ff;

   assign diff  = 18'(in_req.set_point) - 18'(in_req.measurement);
   assign max18 = 18'(E_MAX);
   assign min18 = 18'(E_MIN);

   always_comb begin
      priority if (diff > max18) e_in = E_MAX;
      else if (diff < min18)     e_in = E_MIN;
      else                       e_in = EW'(diff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_val_ff <= 1'b0;
      end else if (en) begin
         e_val_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff <= e_in;
      end
   end

   mode_vec_type                    mode_in, mode_ff;
   logic [NUM_SETS-1:0][GNUM_W-1:0] num_in, num_ff;
   logic [NUM_SETS-1:0][GDEN_W-1:0] den_in, den_ff;
   logic                            val_ff;

   always_comb begin
      logic signed [17:0] e18, a, b, c, d, lo, span;
      e18 = 18'(e_ff);
      for (int s = 0; s < NUM_SETS; s++) begin
         a = 18'($signed(traps[s][15:0]));
         b = 18'($signed(traps[s][31:16]));
         c = 18'($signed(traps[s][47:32]));
         d = 18'($signed(traps[s][63:48]));
         lo   = '0;
         span = 18'sd1;
         priority if (e18 < a) begin
            mode_in[s] = MODE_ZERO;
         end else if (e18 <= b) begin
            mode_in[s] = (a == b) ? MODE_FULL : MODE_RISE;
            lo   = e18 - a;
            span = b - a;
         end else if (e18 <= c) begin
            mode_in[s] = MODE_FULL;
         end else if (e18 <= d) begin
            mode_in[s] = (c == d) ? MODE_FULL : MODE_FALL;
            lo   = e18 - c;
            span = d - c;
         end else begin
            mode_in[s] = MODE_ZERO;
         end
         if (mode_in[s] == MODE_RISE || mode_in[s] == MODE_FALL) begin
            num_in[s] = GNUM_W'(lo[16:0]) * GNUM_W'(GRADE_FULL);
            den_in[s] = span[16:0];
         end else begin
            num_in[s] = '0;
            den_in[s] = GDEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= 1'b0;
      end else if (en) begin
         val_ff <= e_val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode_ff <= mode_in;
         num_ff  <= num_in;
         den_ff  <= den_in;
      end
   end

   assign out.valid = val_ff;
   assign out.mode  = mode_ff;
   assign out.num   = num_ff;
   assign out.den   = den_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/fcfs_defuzz.sv =====
// Grades to weighted sum, weight total and magnitude/sign for the final divide.
`default_nettype none
module fcfs_defuzz (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            en,
   input  logic                                            in_valid,
   input  fcfs_pkg::mode_vec_type                          in_mode,
   input  logic [fcfs_pkg::NUM_SETS-1:0][fcfs_pkg::GRADE_W-1:0] in_quo,
   input  fcfs_pkg::peak_bank_type                         peaks,
   output fcfs_pkg::defuzz_type                            out
);
   import fcfs_pkg::*;

   logic [NUM_SETS-1:0][GRADE_W-1:0]       g_in, g_ff;
   logic signed [NUM_SETS-1:0][PROD_W-1:0] p_in, p_ff;
   logic                                   p_val_ff;

   always_comb begin
      logic signed [23:0] prod;
      for (int s = 0; s < NUM_SETS; s++) begin
         unique case (in_mode[s])
            MODE_ZERO: g_in[s] = '0;
            MODE_FULL: g_in[s] = GRADE_FULL;
            MODE_RISE: g_in[s] = in_quo[s];
            MODE_FALL: g_in[s] = GRADE_FULL - in_quo[s];
            default:   g_in[s] = '0;
         endcase
         prod    = $signed({1'b0, g_in[s]}) * $signed(peaks[s]);
         p_in[s] = prod[PROD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_val_ff <= 1'b0;
      end else if (en) begin
         p_val_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_ff <= g_in;
         p_ff <= p_in;
      end
   end

   logic signed [SUM_W-1:0] num_in, num_ff;
   logic [DEN_W-1:0]        den_in, den_ff;
   logic                    s_val_ff;

   always_comb begin
      num_in = '0;
      den_in = '0;
      for (int s = 0; s < NUM_SETS; s++) begin
         num_in = num_in + SUM_W'($signed(p_ff[s]));
         den_in = den_in + DEN_W'(g_ff[s]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_val_ff <= 1'b0;
      end else if (en) begin
         s_val_ff <= p_val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in;
         den_ff <= den_in;
      end
   end

   defuzz_type m_in, m_ff;
   logic signed [SUM_W-1:0] abs_num;

   assign abs_num = num_ff[SUM_W-1] ? -num_ff : num_ff;

   always_comb begin
      m_in.valid      = s_val_ff;
      m_in.side.empty = (den_ff == '0);
      m_in.side.sign  = num_ff[SUM_W-1];
      m_in.mag        = m_in.side.empty ? '0 : abs_num[MAG_W-1:0];
      m_in.den        = m_in.side.empty ? DEN_W'(1) : den_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff.valid <= 1'b0;
      end else if (en) begin
         m_ff.valid <= m_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff.side <= m_in.side;
         m_ff.mag  <= m_in.mag;
         m_ff.den  <= m_in.den;
      end
   end

   assign out = m_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/fuzzy_controller_five_set_top.sv =====
// Top level of the five-set fuzzy controller: registers, pipeline and output.
// Usage:
//   Write the five trapezoids and the output peaks over the csr_ port while
//   no item is in flight; a write lands at the clock edge where csr_we is high.
//   Items enter on req_valid/req_ready and leave on rsp_valid/rsp_ready.
//   From acceptance to rsp_valid an item passes two front stages, 7 grade
//   divider stages, three defuzz stages, 16 final divider stages and the
//   output register. The restoring dividers retire one quotient bit per
//   stage, which sets the depth.
//   Throughput is one item per cycle; the pipeline only holds while an
//   output item waits with rsp_ready low, and req_ready drops for exactly
//   those cycles, so nothing is dropped or repeated.
//   Reset empties the pipeline and clears every configuration register to zero; with all
//   trapezoids at zero, an error of zero grades fully and any other error
//   yields drive 0 with no_membership set.
`default_nettype none
`include "fuzzy_controller_five_set_top_defines.svh"
module fuzzy_controller_five_set_top #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  fcfs_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output fcfs_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [fcfs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fcfs_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import fcfs_pkg::*;

   trap_bank_type          trap_ff;
   logic [CSR_DATA_W-1:0]  centers_low_ff;
   logic [PT_W-1:0]        center_pl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trap_ff        <= '0;
         centers_low_ff <= '0;
         center_pl_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TRAP_NEG_LARGE:   trap_ff[0]     <= csr_wdata;
            CSR_TRAP_NEG:         trap_ff[1]     <= csr_wdata;
            CSR_TRAP_ZERO:        trap_ff[2]     <= csr_wdata;
            CSR_TRAP_POS:         trap_ff[3]     <= csr_wdata;
            CSR_TRAP_POS_LARGE:   trap_ff[4]     <= csr_wdata;
            CSR_CENTERS_LOW:      centers_low_ff <= csr_wdata;
            CSR_CENTER_POS_LARGE: center_pl_ff   <= csr_wdata[PT_W-1:0];
            default: ;
         endcase
      end
   end

   peak_bank_type peaks;
   assign peaks[0] = centers_low_ff[15:0];
   assign peaks[1] = centers_low_ff[31:16];
   assign peaks[2] = centers_low_ff[47:32];
   assign peaks[3] = centers_low_ff[63:48];
   assign peaks[4] = center_pl_ff;

   // whole pipeline moves together unless the output item is held
   logic    adv;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   front_type front;

   fcfs_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (req_valid),
      .in_req   (req_data),
      .traps    (trap_ff),
      .out      (front)
   );

   logic                             gdiv_valid;
   logic [NUM_SETS-1:0][GRADE_W-1:0] gdiv_quo;
   logic [$bits(mode_vec_type)-1:0]  gdiv_side;
   mode_vec_type                     gmode;

   fcfs_pipe_div #(
      .LANES (NUM_SETS),
      .NW    (GNUM_W),
      .DW    (GDEN_W),
      .QW    (GRADE_W),
      .SW    ($bits(mode_vec_type))
   ) u_grade_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (front.valid),
      .in_num    (front.num),
      .in_den    (front.den),
      .in_side   (front.mode),
      .out_valid (gdiv_valid),
      .out_quo   (gdiv_quo),
      .out_side  (gdiv_side)
   );

   assign gmode = mode_vec_type'(gdiv_side);

   defuzz_type dfz;

   fcfs_defuzz u_defuzz (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (gdiv_valid),
      .in_mode  (gmode),
      .in_quo   (gdiv_quo),
      .peaks    (peaks),
      .out      (dfz)
   );

   logic                  qdiv_valid;
   logic [0:0][DRV_W-1:0] qdiv_quo;
   quo_side_type          qside;

   fcfs_pipe_div #(
      .LANES (1),
      .NW    (MAG_W),
      .DW    (DEN_W),
      .QW    (DRV_W),
      .SW    ($bits(quo_side_type))
   ) u_drive_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (dfz.valid),
      .in_num    (dfz.mag),
      .in_den    (dfz.den),
      .in_side   (dfz.side),
      .out_valid (qdiv_valid),
      .out_quo   (qdiv_quo),
      .out_side  (qside)
   );

   always_comb begin
      rsp_in.no_membership = qside.empty;
      priority if (qside.empty) rsp_in.drive = '0;
      else if (qside.sign)      rsp_in.drive = -qdiv_quo[0];
      else                      rsp_in.drive = qdiv_quo[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= qdiv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   logic grade_ok;
   always_comb begin
      grade_ok = 1'b1;
      for (int s = 0; s < NUM_SETS; s++) begin
         if (gdiv_quo[s] > GRADE_FULL) grade_ok = 1'b0;
      end
   end

   `FCFS_ASSERT_SAME(a_grade_range, clock, reset, gdiv_valid, grade_ok, "grade above full scale")
   `FCFS_ASSERT_SAME(a_drive_range, clock, reset, qdiv_valid && !qside.empty, (qdiv_quo[0] <= 16'd32767) || (qside.sign && (qdiv_quo[0] == 16'h8000)), "drive quotient overflow")
   `FCFS_ASSERT_NEXT(a_out_follow, clock, reset, qdiv_valid && adv, rsp_valid_ff && (rsp_ff.no_membership == $past(qside.empty)), "item lost at output")
   `FCFS_ASSERT_SAME(a_empty_zero, clock, reset, rsp_valid_ff && rsp_ff.no_membership, rsp_ff.drive == '0, "empty item with nonzero drive")
endmodule
`default_nettype wire

// ===== bench/fuzzy_controller_five_set_top_tb.sv =====
// Testbench of the five-set fuzzy controller: directed and random items, self-checking.
`default_nettype none
module fuzzy_controller_five_set_top_tb;
   import fcfs_pkg::*;

   localparam int LATENCY = 29;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   fuzzy_controller_five_set_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow copy of the controller registers
   logic [CSR_DATA_W-1:0] trap_shadow [NUM_SETS];
   logic signed [PT_W-1:0] peak_shadow [NUM_SETS];

   rsp_type expected_drives [$];
   int errors = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_empty = 0;
   longint cycles = 0;
   int send_gap_max = 3;
   int sink_stall_max = 3;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic longint grade_of(logic [CSR_DATA_W-1:0] pts, longint e);
      longint a, b, c, d;
      a = longint'($signed(pts[15:0]));
      b = longint'($signed(pts[31:16]));
      c = longint'($signed(pts[47:32]));
      d = longint'($signed(pts[63:48]));
      if (e < a) return 0;
      if (e <= b) return (a == b) ? 100 : ((e - a) * 100) / (b - a);
      if (e <= c) return 100;
      if (e <= d) return (c == d) ? 100 : 100 - ((e - c) * 100) / (d - c);
      return 0;
   endfunction

   function automatic rsp_type predict_drive(req_type r);
      longint e, g, num, den;
      rsp_type o;
      e = longint'(r.set_point) - longint'(r.measurement);
      if (e > 32767) e = 32767;
      if (e < -32768) e = -32768;
      num = 0;
      den = 0;
      for (int i = 0; i < NUM_SETS; i++) begin
         g = grade_of(trap_shadow[i], e);
         num += g * longint'(peak_shadow[i]);
         den += g;
      end
      o.drive = (den != 0) ? DRV_W'(num / den) : '0;
      o.no_membership = (den == 0);
      return o;
   endfunction

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_CENTERS_LOW) begin
         for (int i = 0; i < 4; i++) peak_shadow[i] = val[16*i +: 16];
      end else if (idx == CSR_CENTER_POS_LARGE) begin
         peak_shadow[4] = val[15:0];
      end else if (idx < CSR_CENTERS_LOW) begin
         trap_shadow[idx] = val;
      end
   endtask

   function automatic int pick_gap(int maxv);
      if ($urandom_range(0, 19) == 0) return $urandom_range(0, 8 * maxv);
      return $urandom_range(0, maxv);
   endfunction

   // one item: random idle gap, then hold valid until accepted; valid stays
   // high afterwards so a following item can go out back to back
   task automatic send_item(logic signed [15:0] sp, logic signed [15:0] ms);
      req_type r;
      int gap;
      r.set_point = sp;
      r.measurement = ms;
      gap = (send_gap_max > 0) ? pick_gap(send_gap_max) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      expected_drives.push_back(predict_drive(r));
      n_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_drives.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      @(negedge clock);
   endtask

   // result sink with random stalls
   initial begin
      forever begin
         @(negedge clock);
         if (sink_stall_max > 0 && $urandom_range(0, 3) == 0)
            rsp_ready <= 1'b0;
         else
            rsp_ready <= 1'b1;
         if (!rsp_ready && $urandom_range(0, 30) == 0)
            repeat (pick_gap(4 * sink_stall_max + 1)) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_drives.size() == 0) begin
            $error("result with nothing expected: drive %0d", rsp_data.drive);
            errors++;
         end else begin
            want = expected_drives.pop_front();
            n_checked++;
            if (want.no_membership) n_empty++;
            if (rsp_data.drive !== want.drive) begin
               $error("drive: expected %0d, actual %0d", want.drive, rsp_data.drive);
               errors++;
            end
            if (rsp_data.no_membership !== want.no_membership) begin
               $error("no_membership: expected %0b, actual %0b",
                      want.no_membership, rsp_data.no_membership);
               errors++;
            end
         end
      end
   end

   function automatic logic [63:0] trap_word(int a, int b, int c, int d);
      return {16'(d), 16'(c), 16'(b), 16'(a)};
   endfunction

   task automatic load_typical();
      write_csr(CSR_TRAP_NEG_LARGE, trap_word(-32768, -32768, -2000, -1000));
      write_csr(CSR_TRAP_NEG, trap_word(-2000, -1000, -1000, 0));
      write_csr(CSR_TRAP_ZERO, trap_word(-1000, 0, 0, 1000));
      write_csr(CSR_TRAP_POS, trap_word(0, 1000, 1000, 2000));
      write_csr(CSR_TRAP_POS_LARGE, trap_word(1000, 2000, 32767, 32767));
      write_csr(CSR_CENTERS_LOW, {16'sd4000, 16'sd0, -16'sd4000, -16'sd20000});
      write_csr(CSR_CENTER_POS_LARGE, 64'(16'sd20000));
   endtask

   task automatic test_reset_defaults();
      send_item(16'sd0, 16'sd0);
      send_item(16'sd5, 16'sd4);
      send_item(-16'sd32768, 16'sd32767);
      send_item(16'sd32767, -16'sd32768);
      drain();
   endtask

   task automatic test_directed();
      load_typical();
      send_item(16'sd0, 16'sd0);
      send_item(16'sd500, 16'sd0);
      send_item(-16'sd1500, 16'sd0);
      send_item(16'sd1500, 16'sd0);
      send_item(16'sd32767, -16'sd32768);
      send_item(-16'sd32768, 16'sd32767);
      send_item(-16'sd1, -16'sd1);
      send_item(16'sd999, -16'sd1);
      send_item(16'sd7, 16'sd0);
      drain();
      // unknown register index is ignored
      write_csr(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(16'sd123, -16'sd321);
      drain();
      // gap between sets: no membership
      write_csr(CSR_TRAP_ZERO, trap_word(-10, -5, 5, 10));
      write_csr(CSR_TRAP_NEG, trap_word(-32768, -32768, -32768, -32768));
      write_csr(CSR_TRAP_POS, trap_word(32767, 32767, 32767, 32767));
      send_item(16'sd0, 16'sd0);
      send_item(16'sd300, 16'sd0);
      send_item(16'sd8, 16'sd0);
      send_item(16'sd32767, -16'sd100);
      drain();
   endtask

   task automatic random_config();
      for (int i = 0; i < NUM_SETS; i++) begin
         int p [4];
         for (int k = 0; k < 4; k++) p[k] = $signed(16'($urandom));
         if ($urandom_range(0, 3) != 0) p.sort();
         write_csr(3'(i), trap_word(p[0], p[1], p[2], p[3]));
      end
      write_csr(CSR_CENTERS_LOW, {$urandom, $urandom});
      write_csr(CSR_CENTER_POS_LARGE, 64'($urandom));
   endtask

   task automatic test_random_phase(int n, int gap, int stall, logic pause_once);
      int sp, ms;
      send_gap_max = gap;
      sink_stall_max = stall;
      for (int j = 0; j < n; j++) begin
         if ($urandom_range(0, 3) == 0) begin
            sp = $urandom;
            ms = $urandom;
         end else begin
            sp = $signed(16'($urandom_range(0, 8000) - 4000));
            ms = $signed(16'($urandom_range(0, 8000) - 4000));
         end
         send_item(16'(sp), 16'(ms));
         if (pause_once && j == n / 2) begin
            req_valid <= 1'b0;
            while (expected_drives.size() != 0) @(posedge clock);
            @(negedge clock);
         end
      end
      drain();
   endtask

   initial begin
      for (int i = 0; i < NUM_SETS; i++) begin
         trap_shadow[i] = '0;
         peak_shadow[i] = '0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed();
      load_typical();
      test_random_phase(400, 3, 3, 1'b1);
      test_random_phase(300, 0, 0, 1'b0);
      for (int ph = 0; ph < 5; ph++) begin
         random_config();
         test_random_phase(200, 2, 4, 1'b0);
      end
      write_csr(CSR_CENTERS_LOW, 64'h8000_7FFF_8000_7FFF);
      write_csr(CSR_CENTER_POS_LARGE, 64'h0000_0000_0000_8000);
      test_random_phase(150, 1, 1, 1'b0);
      $display("covered %0d items, %0d results checked, %0d with no membership",
               n_sent, n_checked, n_empty);
      $display("reset defaults, fixed and random set shapes, peak extremes, stalls");
      if (errors == 0 && expected_drives.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/fcfs_pkg.sv
hw/rtl/fcfs_pipe_div.sv
hw/rtl/fcfs_front.sv
hw/rtl/fcfs_defuzz.sv
hw/rtl/fuzzy_controller_five_set_top.sv
bench/fuzzy_controller_five_set_top_tb.sv
